// ===== sv/bog_pkg.sv =====
// Shared types, widths and helpers of the broadcast offset generator.
// No dependencies; every other file imports this package.
package bog_pkg;

  localparam int unsigned IdxW    = 32;
  localparam int unsigned ExtW    = 16;
  localparam int unsigned OffW    = 48;
  localparam int unsigned ShapeW  = 64;
  localparam int unsigned SizeW   = 32;
  localparam int unsigned EbW     = 4;
  localparam int unsigned DimsW   = 3;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 64;
  localparam int unsigned HalfW   = OffW / 2;
  localparam int unsigned DefMaxDims = 4;

  // Register indexes of the configuration port.
  typedef enum logic [CfgIdxW-1:0] {
    CfgBatchDims   = 3'd0,
    CfgFirstShape  = 3'd1,
    CfgSecondShape = 3'd2,
    CfgFirstInner  = 3'd3,
    CfgSecondInner = 3'd4,
    CfgElemBytes   = 3'd5
  } bog_cfg_idx_e;

  // Data handed from cell to cell along the chain.
  typedef struct packed {
    logic [IdxW-1:0] quo;
    logic [ExtW-1:0] rem;
    logic [OffW-1:0] row_a;
    logic [OffW-1:0] row_b;
    logic [OffW-1:0] wgt_a;
    logic [OffW-1:0] wgt_b;
  } bog_pkt_t;

  // Extent of one dimension from a packed shape word.
  function automatic logic [ExtW-1:0] extent_of(logic [ShapeW-1:0] packed_shape,
                                                logic [1:0] dim);
    extent_of = packed_shape[dim*ExtW +: ExtW];
  endfunction

endpackage

// ===== sv/bog_div_cell.sv =====
// One restoring-division step: produces one quotient bit of the index digit.
// Depends on bog_pkg.
module bog_div_cell (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     active_i,
  input  logic [bog_pkg::ExtW-1:0] ec_i,
  input  logic                     valid_i,
  input  bog_pkg::bog_pkt_t        pkt_i,
  output logic                     valid_o,
  output bog_pkg::bog_pkt_t        pkt_o
);
  import bog_pkg::*;

  logic [ExtW:0]  trial;
  logic           take;
  bog_pkt_t       pkt_d;
  logic           valid_q;
  bog_pkt_t       pkt_q;

  // Shift the next dividend bit into the partial remainder and try a subtract.
  always_comb begin
    trial = {pkt_i.rem, pkt_i.quo[IdxW-1]};
    take  = (trial >= {1'b0, ec_i});
    pkt_d = pkt_i;
    if (active_i) begin
      pkt_d.quo = {pkt_i.quo[IdxW-2:0], take};
      pkt_d.rem = take ? ExtW'(trial - {1'b0, ec_i}) : trial[ExtW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pkt_q <= pkt_d;
    end
  end

  assign valid_o = valid_q;
  assign pkt_o   = pkt_q;

endmodule

// ===== sv/bog_acc_cell.sv =====
// Weights the finished digit of one dimension into each row number that uses it.
// Depends on bog_pkg.
module bog_acc_cell (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     active_i,
  input  logic [bog_pkg::ExtW-1:0] ea_i,
  input  logic [bog_pkg::ExtW-1:0] eb_i,
  input  logic [bog_pkg::ExtW-1:0] ec_i,
  input  logic                     valid_i,
  input  bog_pkg::bog_pkt_t        pkt_i,
  output logic                     valid_o,
  output bog_pkg::bog_pkt_t        pkt_o
);
  import bog_pkg::*;

  logic [63:0] term_a;
  logic [63:0] term_b;
  logic [63:0] scale_a;
  logic [63:0] scale_b;
  logic        use_a;
  logic        use_b;
  bog_pkt_t    pkt_d;
  logic        valid_q;
  bog_pkt_t    pkt_q;

  // A dimension counts only where the input extent matches the output extent
  // and is not one.
  always_comb begin
    use_a   = (ea_i == ec_i) && (ea_i != ExtW'(1));
    use_b   = (eb_i == ec_i) && (eb_i != ExtW'(1));
    term_a  = {48'd0, pkt_i.rem} * {16'd0, pkt_i.wgt_a};
    term_b  = {48'd0, pkt_i.rem} * {16'd0, pkt_i.wgt_b};
    scale_a = {16'd0, pkt_i.wgt_a} * {48'd0, ea_i};
    scale_b = {16'd0, pkt_i.wgt_b} * {48'd0, eb_i};
    pkt_d     = pkt_i;
    pkt_d.rem = '0;
    if (active_i) begin
      if (use_a) begin
        pkt_d.row_a = pkt_i.row_a + term_a[OffW-1:0];
      end
      if (use_b) begin
        pkt_d.row_b = pkt_i.row_b + term_b[OffW-1:0];
      end
      pkt_d.wgt_a = scale_a[OffW-1:0];
      pkt_d.wgt_b = scale_b[OffW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pkt_q <= pkt_d;
    end
  end

  assign valid_o = valid_q;
  assign pkt_o   = pkt_q;

endmodule

// ===== sv/bog_scale.sv =====
// Scales both row numbers by inner size and element size over three stages.
// Depends on bog_pkg; the last stage is the output register.
module bog_scale (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [bog_pkg::OffW-1:0]  row_a_i,
  input  logic [bog_pkg::OffW-1:0]  row_b_i,
  input  logic [bog_pkg::SizeW-1:0] inner_a_i,
  input  logic [bog_pkg::SizeW-1:0] inner_b_i,
  input  logic [bog_pkg::EbW-1:0]   elem_bytes_i,
  input  logic                      zero_i,
  output logic                      valid_o,
  output logic [bog_pkg::OffW-1:0]  off_a_o,
  output logic [bog_pkg::OffW-1:0]  off_b_o
);
  import bog_pkg::*;

  logic [55:0]     lo_a_full, lo_b_full;
  logic [47:0]     hi_a_full, hi_b_full;
  logic [OffW-1:0] lo_a_q, lo_b_q;
  logic [HalfW-1:0] hi_a_q, hi_b_q;
  logic [OffW-1:0] prod_a_q, prod_b_q;
  logic [OffW-1:0] sum_a, sum_b;
  logic [51:0]     byte_a, byte_b;
  logic [OffW-1:0] off_a_q, off_b_q;
  logic [2:0]      valid_q;

  // Partial products of row times inner size, modulo the offset width.
  always_comb begin
    lo_a_full = {8'd0, row_a_i[HalfW-1:0]} * {24'd0, inner_a_i};
    lo_b_full = {8'd0, row_b_i[HalfW-1:0]} * {24'd0, inner_b_i};
    hi_a_full = {24'd0, row_a_i[OffW-1:HalfW]} * {24'd0, inner_a_i[HalfW-1:0]};
    hi_b_full = {24'd0, row_b_i[OffW-1:HalfW]} * {24'd0, inner_b_i[HalfW-1:0]};
    sum_a     = lo_a_q + {hi_a_q, {HalfW{1'b0}}};
    sum_b     = lo_b_q + {hi_b_q, {HalfW{1'b0}}};
    byte_a    = {4'd0, prod_a_q} * {48'd0, elem_bytes_i};
    byte_b    = {4'd0, prod_b_q} * {48'd0, elem_bytes_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[1:0], valid_i};
    end
  end

  // Zero extents in use force both offsets to zero at the last stage.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lo_a_q   <= lo_a_full[OffW-1:0];
      lo_b_q   <= lo_b_full[OffW-1:0];
      hi_a_q   <= hi_a_full[HalfW-1:0];
      hi_b_q   <= hi_b_full[HalfW-1:0];
      prod_a_q <= sum_a;
      prod_b_q <= sum_b;
      off_a_q  <= zero_i ? '0 : byte_a[OffW-1:0];
      off_b_q  <= zero_i ? '0 : byte_b[OffW-1:0];
    end
  end

  assign valid_o = valid_q[2];
  assign off_a_o = off_a_q;
  assign off_b_o = off_b_q;

endmodule

// ===== sv/broadcast_offset_generator_unit.sv =====
// Top level of the broadcast offset generator: configuration registers,
// chain of division and accumulation cells, and output scaling.
// Depends on bog_pkg, bog_div_cell, bog_acc_cell and bog_scale.
//
//   Channel   Handshake                  Payload
//   input     in_valid_i / in_stall_o    batch_index_i
//   output    out_valid_o / out_stall_i  first_offset_o, second_offset_o
//   config    cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// One item enters per cycle unless the input is stalled; the path runs through 32
// one-bit division cells and one accumulation cell per dimension, then three
// scaling stages. Reset clears valid bits and restores register defaults.
// A result stalled at the output is moved into a holding register while the
// chain keeps running for that cycle; the chain and the input are stalled
// only while the holding register is full, up to and including the cycle of
// its transfer.
module broadcast_offset_generator_unit #(
  parameter int unsigned MAX_DIMS = bog_pkg::DefMaxDims
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [bog_pkg::IdxW-1:0]    batch_index_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [bog_pkg::OffW-1:0]    first_offset_o,
  output logic [bog_pkg::OffW-1:0]    second_offset_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [bog_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [bog_pkg::CfgW-1:0]    cfg_data_i
);
  import bog_pkg::*;

  localparam int unsigned CellsPerDim = IdxW + 1;
  localparam int unsigned NumStages   = MAX_DIMS * CellsPerDim;

  logic [DimsW-1:0]  dims_q;
  logic [ShapeW-1:0] shape_a_q, shape_b_q;
  logic [SizeW-1:0]  inner_a_q, inner_b_q;
  logic [EbW-1:0]    elem_bytes_q;
  logic [DimsW-1:0]  dims_used;
  logic              en;
  logic [MAX_DIMS-1:0] ext_zero;
  logic              zero_ext;
  logic              chain_valid [NumStages+1];
  bog_pkt_t          chain_pkt   [NumStages+1];
  logic              scale_valid;
  logic [OffW-1:0]   scale_off_a, scale_off_b;
  logic              hold_valid_d, hold_valid_q;
  logic [OffW-1:0]   hold_a_q, hold_b_q;

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_q       <= '0;
      shape_a_q    <= '0;
      shape_b_q    <= '0;
      inner_a_q    <= SizeW'(1);
      inner_b_q    <= SizeW'(1);
      elem_bytes_q <= EbW'(4);
    end else if (cfg_valid_i) begin
      case (bog_cfg_idx_e'(cfg_index_i))
        CfgBatchDims:   dims_q       <= cfg_data_i[DimsW-1:0];
        CfgFirstShape:  shape_a_q    <= cfg_data_i;
        CfgSecondShape: shape_b_q    <= cfg_data_i;
        CfgFirstInner:  inner_a_q    <= cfg_data_i[SizeW-1:0];
        CfgSecondInner: inner_b_q    <= cfg_data_i[SizeW-1:0];
        CfgElemBytes:   elem_bytes_q <= cfg_data_i[EbW-1:0];
        default: ;
      endcase
    end
  end

  // Dimensions beyond the supported count are ignored.
  assign dims_used = (dims_q > DimsW'(MAX_DIMS)) ? DimsW'(MAX_DIMS) : dims_q;

  // The chain moves unless the holding register is occupied.
  assign en         = !hold_valid_q;
  assign in_stall_o = hold_valid_q;

  assign chain_valid[0] = in_valid_i && !in_stall_o;
  assign chain_pkt[0]   = '{quo: batch_index_i, rem: '0, row_a: '0, row_b: '0,
                            wgt_a: OffW'(1), wgt_b: OffW'(1)};

  // Least significant dimension first; slots past the dimension count pass through.
  for (genvar k = 0; k < MAX_DIMS; k++) begin : g_dim
    localparam int unsigned Dim  = MAX_DIMS - 1 - k;
    localparam int unsigned Base = k * CellsPerDim;
    logic [ExtW-1:0] ea, eb, ec;
    logic            active;

    assign ea          = extent_of(shape_a_q, 2'(Dim));
    assign eb          = extent_of(shape_b_q, 2'(Dim));
    assign ec          = (ea > eb) ? ea : eb;
    assign active      = (DimsW'(Dim) < dims_used);
    assign ext_zero[k] = active && (ec == '0);

    for (genvar b = 0; b < IdxW; b++) begin : g_bit
      bog_div_cell u_div (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .en_i     (en),
        .active_i (active),
        .ec_i     (ec),
        .valid_i  (chain_valid[Base+b]),
        .pkt_i    (chain_pkt[Base+b]),
        .valid_o  (chain_valid[Base+b+1]),
        .pkt_o    (chain_pkt[Base+b+1])
      );
    end

    bog_acc_cell u_acc (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (en),
      .active_i (active),
      .ea_i     (ea),
      .eb_i     (eb),
      .ec_i     (ec),
      .valid_i  (chain_valid[Base+IdxW]),
      .pkt_i    (chain_pkt[Base+IdxW]),
      .valid_o  (chain_valid[Base+CellsPerDim]),
      .pkt_o    (chain_pkt[Base+CellsPerDim])
    );
  end

  assign zero_ext = |ext_zero;

  bog_scale u_scale (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .valid_i      (chain_valid[NumStages]),
    .row_a_i      (chain_pkt[NumStages].row_a),
    .row_b_i      (chain_pkt[NumStages].row_b),
    .inner_a_i    (inner_a_q),
    .inner_b_i    (inner_b_q),
    .elem_bytes_i (elem_bytes_q),
    .zero_i       (zero_ext),
    .valid_o      (scale_valid),
    .off_a_o      (scale_off_a),
    .off_b_o      (scale_off_b)
  );

  // A stalled result is parked in the holding register until its transfer.
  always_comb begin
    hold_valid_d = hold_valid_q;
    if (hold_valid_q) begin
      if (!out_stall_i) begin
        hold_valid_d = 1'b0;
      end
    end else if (scale_valid && out_stall_i) begin
      hold_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
    end else begin
      hold_valid_q <= hold_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!hold_valid_q && scale_valid && out_stall_i) begin
      hold_a_q <= scale_off_a;
      hold_b_q <= scale_off_b;
    end
  end

  // The parked result goes first; otherwise the last scaling stage is shown.
  assign out_valid_o     = hold_valid_q || scale_valid;
  assign first_offset_o  = hold_valid_q ? hold_a_q : scale_off_a;
  assign second_offset_o = hold_valid_q ? hold_b_q : scale_off_b;

  // Input is stalled only while a result is waiting at the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled without a waiting result");

  // A result leaves only through a completed transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_o) |-> $past(!out_stall_i))
    else $error("result dropped while stalled");

  // A held result keeps its offsets.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(out_valid_o && out_stall_i) |-> ($stable(first_offset_o) &&
                                           $stable(second_offset_o)))
    else $error("held result changed");

endmodule
